@@ sv/tlik_pkg.sv @@
package tlik_pkg;

	localparam int FRAC_BITS = 10;

	localparam int X_W   = 10;
	localparam int SH_W  = 13;
	localparam int EL_W  = 11;
	localparam int R2_W  = 20;
	localparam int ND_W  = 20;
	localparam int V_W   = 16;
	localparam int ANG_W = 10;

	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int SQ_W      = 32;
	localparam int SQ_STEPS  = SQ_W / 2;
	localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
	localparam int MUL_W     = 17;
	localparam int PROD_W    = 32;
	localparam int MUL_CNT_W = $clog2(MUL_W);

	localparam int R_W = FRAC_BITS + 2;
	localparam int T_W = FRAC_BITS + 9;

	localparam logic [R2_W-1:0]        REACH_SQ    = 20'd90000;
	localparam logic signed [ND_W-1:0] REACH       = 20'sd300;
	localparam logic [ND_W-1:0]        SCALE_LIM_U = 20'd10000;
	localparam logic signed [ND_W-1:0] SCALE_LIM_S = 20'sd10000;
	localparam int                     SCALE_SHIFT = 6;
	localparam logic [DIV_W-1:0]       DIV_TEN     = 32'd10;

	typedef logic signed [X_W-1:0] coord_t;

endpackage

@@ sv/tlik_req_if.sv @@
interface tlik_req_if;
	import tlik_pkg::*;
	logic   valid;
	logic   ready;
	coord_t target_x;
	coord_t target_y;
	modport source (output valid, output target_x, output target_y, input ready);
	modport sink (input valid, input target_x, input target_y, output ready);
endinterface

@@ sv/tlik_rsp_if.sv @@
interface tlik_rsp_if;
	import tlik_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [SH_W-1:0] shoulder_angle;
	logic [EL_W-1:0]        elbow_angle;
	logic                   in_reach;
	modport source (output valid, output shoulder_angle, output elbow_angle,
		output in_reach, input ready);
	modport sink (input valid, input shoulder_angle, input elbow_angle,
		input in_reach, output ready);
endinterface

@@ sv/two_link_inverse_kinematics.sv @@
// in reach: the sequence runs the serial multiplier (17 steps), the square root unit
// (16 steps, three times) and the divider (32 steps, up to four times), and skips one
// division for each angle whose opposite side is zero; out of reach: no unit is started
// one item at a time: the next input transfer waits until the result is in the output
// register, and the result waits while the output register holds an untaken result
// arst_n clears the sequencer and the output valid; no result is pending after reset
module two_link_inverse_kinematics (
	input  logic  clk,
	input  logic  arst_n,
	tlik_req_if.sink   req,
	tlik_rsp_if.source rsp
);
	import tlik_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SQR  = 5'd1;
	localparam logic [4:0] ST_CHK  = 5'd2;
	localparam logic [4:0] ST_MUL  = 5'd3;
	localparam logic [4:0] ST_RT1  = 5'd4;
	localparam logic [4:0] ST_SCL  = 5'd5;
	localparam logic [4:0] ST_DV1  = 5'd6;
	localparam logic [4:0] ST_DV2  = 5'd7;
	localparam logic [4:0] ST_AT0  = 5'd8;
	localparam logic [4:0] ST_ATD  = 5'd9;
	localparam logic [4:0] ST_AM1  = 5'd10;
	localparam logic [4:0] ST_AM2  = 5'd11;
	localparam logic [4:0] ST_AM3  = 5'd12;
	localparam logic [4:0] ST_AM4  = 5'd13;
	localparam logic [4:0] ST_AEND = 5'd14;
	localparam logic [4:0] ST_RT2  = 5'd15;
	localparam logic [4:0] ST_RT3  = 5'd16;
	localparam logic [4:0] ST_FIN  = 5'd17;

	localparam logic signed [ANG_W-1:0] ANG_0   = 10'sd0;
	localparam logic signed [ANG_W-1:0] ANG_45  = 10'sd45;
	localparam logic signed [ANG_W-1:0] ANG_135 = 10'sd135;
	localparam logic signed [ANG_W-1:0] ANG_180 = 10'sd180;

	logic [4:0] state_q;

	coord_t                   x_q;
	coord_t                   y_q;
	logic [R2_W-1:0]          r2_q;
	logic signed [ND_W-1:0]   num_q;
	logic signed [ND_W-1:0]   den_q;
	logic                     neg_q;
	logic signed [V_W-1:0]    yv_q;
	logic signed [V_W-1:0]    xv_q;
	logic                     rneg_q;
	logic signed [ANG_W-1:0]  base_q;
	logic signed [R_W-1:0]    r_q;
	logic signed [2*R_W-1:0]  rr_q;
	logic signed [2*R_W-1:0]  r3_q;
	logic signed [T_W-1:0]    t_q;
	logic signed [ANG_W-1:0]  ang_q;
	logic                     phase_q;
	logic signed [SH_W-1:0]   sh_q;
	logic [EL_W-1:0]          el_q;
	logic                     reach_q;

	logic                     out_v_q;
	logic signed [SH_W-1:0]   sh_out_q;
	logic [EL_W-1:0]          el_out_q;
	logic                     rch_out_q;

	logic                     mul_start;
	logic [MUL_W-1:0]         mul_a;
	logic [MUL_W-1:0]         mul_b;
	logic                     mul_done;
	logic [PROD_W-1:0]        mul_prod;
	logic                     sq_start;
	logic [SQ_W-1:0]          sq_in;
	logic                     sq_done;
	logic [SQ_STEPS-1:0]      sq_root;
	logic                     div_start;
	logic [DIV_W-1:0]         div_a;
	logic [DIV_W-1:0]         div_b;
	logic                     div_done;
	logic [DIV_W-1:0]         div_q;

	logic signed [ND_W-1:0]   xsq;
	logic signed [ND_W-1:0]   ysq;
	logic signed [ND_W-1:0]   num_w;
	logic signed [ND_W-1:0]   den_w;
	logic [ND_W-1:0]          mag_raw;
	logic                     big;
	logic [ND_W-1:0]          mag_sc;
	logic signed [ND_W-1:0]   den_sc;
	logic [ND_W-1:0]          dmag;
	logic                     xnn;
	logic signed [V_W-1:0]    n_w;
	logic signed [V_W-1:0]    d_w;
	logic [V_W-1:0]           nmag;
	logic signed [R_W-1:0]    q_r;
	logic signed [R_W-1:0]    rrs;
	logic signed [R_W-1:0]    r3s;
	logic signed [T_W-1:0]    r3x;
	logic signed [T_W-1:0]    rx;
	logic signed [SH_W-1:0]   ax;
	logic signed [SH_W-1:0]   jw;
	logic                     load_out;

	tlik_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
		.done(mul_done), .product(mul_prod)
	);

	tlik_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.done(sq_done), .root(sq_root)
	);

	tlik_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		xsq     = ND_W'(x_q) * ND_W'(x_q);
		ysq     = ND_W'(y_q) * ND_W'(y_q);
		num_w   = ND_W'(y_q) * REACH - $signed({{(ND_W - SQ_STEPS){1'b0}}, sq_root});
		den_w   = $signed(r2_q) + ND_W'(x_q) * REACH;
		mag_raw = num_q[ND_W-1] ? ND_W'(-num_q) : ND_W'(num_q);
		big     = (mag_raw > SCALE_LIM_U) || (den_q > SCALE_LIM_S);
		mag_sc  = big ? (mag_raw >> SCALE_SHIFT) : mag_raw;
		den_sc  = big ? (den_q >>> SCALE_SHIFT) : den_q;
		dmag    = den_q[ND_W-1] ? ND_W'(-den_q) : ND_W'(den_q);
		xnn     = !xv_q[V_W-1];
		n_w     = xnn ? (xv_q - yv_q) : (xv_q + yv_q);
		d_w     = xnn ? (xv_q + yv_q) : (yv_q - xv_q);
		nmag    = n_w[V_W-1] ? V_W'(-n_w) : V_W'(n_w);
		q_r     = $signed(div_q[R_W-1:0]);
		rrs     = R_W'(rr_q >>> FRAC_BITS);
		r3s     = R_W'(r3_q >>> FRAC_BITS);
		r3x     = T_W'(r3s);
		rx      = T_W'(r_q);
		ax      = SH_W'(ang_q);
		jw      = (ax <<< 4) + (ax <<< 2);
	end

	// launches of the shared serial units
	always_comb begin
		mul_start = 1'b0;
		mul_a     = r2_q[MUL_W-1:0];
		mul_b     = MUL_W'(REACH_SQ - r2_q);
		sq_start  = 1'b0;
		sq_in     = mul_prod;
		div_start = 1'b0;
		div_a     = DIV_W'(mag_sc);
		div_b     = DIV_TEN;
		unique case (state_q)
			ST_CHK: begin
				mul_start = r2_q < REACH_SQ;
			end
			ST_MUL: begin
				sq_start = mul_done;
			end
			ST_AEND: begin
				sq_start = !phase_q;
				sq_in    = SQ_W'(REACH_SQ - r2_q);
			end
			ST_RT2: begin
				sq_start = sq_done;
				sq_in    = SQ_W'(r2_q);
			end
			ST_SCL: begin
				div_start = 1'b1;
			end
			ST_DV1: begin
				div_start = div_done;
				div_a     = DIV_W'(dmag);
			end
			ST_AT0: begin
				div_start = yv_q != '0;
				div_a     = DIV_W'(nmag) << FRAC_BITS;
				div_b     = DIV_W'($unsigned(d_w));
			end
			default: begin
			end
		endcase
	end

	assign load_out = (state_q == ST_FIN) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req.valid) state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_CHK;
				ST_CHK:  state_q <= (r2_q < REACH_SQ) ? ST_MUL : ST_FIN;
				ST_MUL:  if (mul_done) state_q <= ST_RT1;
				ST_RT1:  if (sq_done) state_q <= ST_SCL;
				ST_SCL:  state_q <= ST_DV1;
				ST_DV1:  if (div_done) state_q <= ST_DV2;
				ST_DV2: begin
					if (div_done) begin
						state_q <= ST_AT0;
						phase_q <= 1'b0;
					end
				end
				ST_AT0:  state_q <= (yv_q != '0) ? ST_ATD : ST_AEND;
				ST_ATD:  if (div_done) state_q <= ST_AM1;
				ST_AM1:  state_q <= ST_AM2;
				ST_AM2:  state_q <= ST_AM3;
				ST_AM3:  state_q <= ST_AM4;
				ST_AM4:  state_q <= ST_AEND;
				ST_AEND: begin
					if (!phase_q) begin
						state_q <= ST_RT2;
						phase_q <= 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_RT2:  if (sq_done) state_q <= ST_RT3;
				ST_RT3:  if (sq_done) state_q <= ST_AT0;
				ST_FIN:  if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= req.target_x;
				y_q <= req.target_y;
			end
			ST_SQR: begin
				r2_q <= $unsigned(xsq + ysq);
			end
			ST_CHK: begin
				reach_q <= r2_q < REACH_SQ;
				sh_q    <= '0;
				el_q    <= '0;
			end
			ST_RT1: begin
				num_q <= num_w;
				den_q <= den_w;
			end
			ST_SCL: begin
				neg_q <= num_q[ND_W-1];
				den_q <= den_sc;
			end
			ST_DV1: begin
				if (div_done) yv_q <= $signed(div_q[V_W-1:0]);
			end
			ST_DV2: begin
				if (div_done) begin
					xv_q <= den_q[ND_W-1] ? -$signed(div_q[V_W-1:0])
						: $signed(div_q[V_W-1:0]);
				end
			end
			ST_AT0: begin
				base_q <= xnn ? ANG_45 : ANG_135;
				rneg_q <= n_w[V_W-1];
				ang_q  <= xnn ? ANG_0 : ANG_180;
			end
			ST_ATD: begin
				if (div_done) r_q <= rneg_q ? -q_r : q_r;
			end
			ST_AM1: rr_q <= (2*R_W)'(r_q) * (2*R_W)'(r_q);
			ST_AM2: r3_q <= (2*R_W)'(rrs) * (2*R_W)'(r_q);
			ST_AM3: begin
				t_q <= (r3x <<< 3) + (r3x <<< 1) + r3x - ((rx <<< 6) - (rx <<< 3));
			end
			ST_AM4: ang_q <= base_q + ANG_W'(t_q >>> FRAC_BITS);
			ST_AEND: begin
				if (!phase_q) sh_q <= neg_q ? -jw : jw;
				else el_q <= EL_W'($unsigned(jw));
			end
			ST_RT2: begin
				if (sq_done) yv_q <= $signed(V_W'(sq_root));
			end
			ST_RT3: begin
				if (sq_done) xv_q <= $signed(V_W'(sq_root));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sh_out_q  <= sh_q;
			el_out_q  <= el_q;
			rch_out_q <= reach_q;
		end
	end

	assign req.ready          = state_q == ST_IDLE;
	assign rsp.valid          = out_v_q;
	assign rsp.shoulder_angle = sh_out_q;
	assign rsp.elbow_angle    = el_out_q;
	assign rsp.in_reach       = rch_out_q;

	a_out_of_reach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.in_reach |-> rsp.shoulder_angle == '0 && rsp.elbow_angle == '0)
		else $error("out of reach result with nonzero angle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_SQR)
		else $error("transfer did not start the sequence");

	a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_RT1 || state_q == ST_RT2 || state_q == ST_RT3)
		else $error("square root finished outside a wait state");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.elbow_angle <= 11'd1800)
		else $error("elbow angle out of range");
endmodule

@@ sv/tlik_mul.sv @@
module tlik_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tlik_pkg::MUL_W-1:0]     op_a,
	input  logic [tlik_pkg::MUL_W-1:0]     op_b,
	output logic                           done,
	output logic [tlik_pkg::PROD_W-1:0]    product
);
	import tlik_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_W-1:0]     a_q;
	logic [PROD_W-1:0]    b_q;
	logic [PROD_W-1:0]    acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= op_a;
			b_q    <= PROD_W'(op_b);
			acc_q  <= '0;
		end else if (busy_q) begin
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
			a_q   <= a_q >> 1;
			b_q   <= b_q << 1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

@@ sv/tlik_sqrt.sv @@
module tlik_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tlik_pkg::SQ_W-1:0]       radicand,
	output logic                            done,
	output logic [tlik_pkg::SQ_STEPS-1:0]   root
);
	import tlik_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic [SQ_W-1:0]     root_q;
	logic [SQ_W-1:0]     rem_q;
	logic [SQ_W-1:0]     bit_q;
	logic [SQ_W-1:0]     trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			root_q <= '0;
			rem_q  <= '0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			root_q <= '0;
			rem_q  <= radicand;
			bit_q  <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q[SQ_STEPS-1:0];
endmodule

@@ sv/tlik_div.sv @@
module tlik_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tlik_pkg::DIV_W-1:0]   dividend,
	input  logic [tlik_pkg::DIV_W-1:0]   divisor,
	output logic                         done,
	output logic [tlik_pkg::DIV_W-1:0]   quotient
);
	import tlik_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W:0]       rem_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       rem_sh;

	assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ test/tlik_ik_checker.sv @@
module tlik_ik_checker (
	input  logic       clk,
	input  logic       arst_n,
	tlik_req_if.sink   req,
	tlik_rsp_if.sink   rsp,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlik_pkg::*;

	typedef struct packed {
		logic signed [SH_W-1:0] shoulder;
		logic [EL_W-1:0]        elbow;
		logic                   reach;
	} joint_set_t;

	joint_set_t expected_joints[$];

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint floor_root(longint v);
		longint bit_w, root, rest, t;
		bit_w = longint'(1) << 30;
		root = 0;
		rest = v;
		while (bit_w > rest)
			bit_w = bit_w >> 2;
		while (bit_w > 0) begin
			t = root + bit_w;
			root = root >> 1;
			if (rest >= t) begin
				rest = rest - t;
				root = root + bit_w;
			end
			bit_w = bit_w >> 2;
		end
		return root;
	endfunction

	function automatic longint approx_atan2(longint yv, longint xv);
		longint ay, r, r3, base, ang;
		ay = (yv < 0) ? -yv : yv;
		if (yv == 0)
			return (xv >= 0) ? 0 : 180;
		if (xv >= 0) begin
			r = ((xv - ay) * (longint'(1) << FRAC_BITS)) / (xv + ay);
			base = 45;
		end else begin
			r = ((xv + ay) * (longint'(1) << FRAC_BITS)) / (ay - xv);
			base = 135;
		end
		r3 = floor_shift(r * r, FRAC_BITS);
		r3 = floor_shift(r3 * r, FRAC_BITS) * 11;
		ang = base + floor_shift(-56 * r + r3, FRAC_BITS);
		return (yv < 0) ? -ang : ang;
	endfunction

	function automatic joint_set_t solve_joints(coord_t tx, coord_t ty);
		joint_set_t js;
		longint x, y, r2, num, den, j1, j2;
		logic neg;
		x = tx;
		y = ty;
		r2 = x * x + y * y;
		js = '0;
		if (r2 >= 90000)
			return js;
		num = 300 * y - floor_root((r2 * (90000 - r2)) & 64'hFFFF_FFFF);
		den = r2 + 300 * x;
		neg = num < 0;
		if (neg)
			num = -num;
		if (num > 10000 || den > 10000) begin
			num = floor_shift(num, SCALE_SHIFT);
			den = floor_shift(den, SCALE_SHIFT);
		end
		j1 = 20 * approx_atan2(num / 10, den / 10);
		if (neg)
			j1 = -j1;
		j2 = 20 * approx_atan2(floor_root(90000 - r2), floor_root(r2));
		js.shoulder = j1[SH_W-1:0];
		js.elbow = j2[EL_W-1:0];
		js.reach = 1'b1;
		return js;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	assign pending = expected_joints.size();

	initial errors = 0;

	always @(posedge clk) begin
		joint_set_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_joints.push_back(solve_joints(req.target_x, req.target_y));
			if (rsp.valid && rsp.ready) begin
				if (expected_joints.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_joints.pop_front();
					if (rsp.shoulder_angle !== want.shoulder)
						report_mismatch($sformatf("shoulder %0d want %0d",
							rsp.shoulder_angle, want.shoulder));
					if (rsp.elbow_angle !== want.elbow)
						report_mismatch($sformatf("elbow %0d want %0d",
							rsp.elbow_angle, want.elbow));
					if (rsp.in_reach !== want.reach)
						report_mismatch($sformatf("in_reach %0b want %0b",
							rsp.in_reach, want.reach));
				end
			end
		end
	end
endmodule

@@ test/two_link_inverse_kinematics_test.sv @@
module two_link_inverse_kinematics_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tlik_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	longint cycles = 0;

	tlik_req_if req ();
	tlik_rsp_if rsp ();

	two_link_inverse_kinematics dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	tlik_ik_checker checker_i (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending));

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2_000_000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_point(int px, int py);
		req.target_x <= coord_t'(px);
		req.target_y <= coord_t'(py);
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_random_point();
		int px, py, kind;
		kind = $urandom_range(9);
		if (kind < 7) begin
			px = $urandom_range(598) - 299;
			py = $urandom_range(598) - 299;
			while (px * px + py * py >= 90000) begin
				px = px / 2;
				py = py / 2;
			end
		end else if (kind < 9) begin
			px = $urandom_range(1022) - 511;
			py = $urandom_range(1022) - 511;
		end else begin
			px = $urandom_range(20) - 10;
			py = $urandom_range(20) - 10;
		end
		send_point(px, py);
	endtask

	initial begin
		int dx[$], dy[$];
		req.valid = 1'b0;
		req.target_x = '0;
		req.target_y = '0;
		rsp.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// zero, axes, reach boundary, field extremes, all quadrants
		dx = '{0, 299, -299, 0, 0, 300, 212, 211, -511, 511, -511, 511, -512, 100, -100,
			-150, 150, 1, -1, 0, 0, 0};
		dy = '{0, 0, 0, 299, -299, 0, 212, 212, -511, 511, 511, -511, -512, 100, 100,
			-150, -150, 0, 0, 1, -1, -512};
		foreach (dx[i])
			send_point(dx[i], dy[i]);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 27) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 78 : 27) : 0;
			for (int n = 0; n < 220; n++)
				send_random_point();
			req.valid <= 1'b0;
			// hold off until everything is back
			while (pending != 0)
				@(negedge clk);
		end
		stall_pct = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ sim.f @@
sv/tlik_pkg.sv
sv/tlik_req_if.sv
sv/tlik_rsp_if.sv
sv/tlik_mul.sv
sv/tlik_sqrt.sv
sv/tlik_div.sv
sv/two_link_inverse_kinematics.sv
test/tlik_ik_checker.sv
test/two_link_inverse_kinematics_test.sv
